// ===== sv/frts_pkg.sv =====
// Shared types, constants and helper functions of the filtered ring top-k selector.
package frts_pkg;

  localparam int RAW_W    = 18;
  localparam int SCORE_W  = 16;
  localparam int DIFF_W   = 17;
  localparam int SLOT_W   = 10;
  localparam int ACC_W    = 25;
  localparam int CNT_W    = 32;
  localparam int SEL_W    = 7;
  localparam int QUO_W    = 25;
  localparam int THRESH_W = 16;

  localparam logic [THRESH_W-1:0] THRESH_DEFAULT = 16'd6554;
  localparam logic [SCORE_W-1:0]  ONE_Q15        = 16'd32768;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  // One ranked candidate as it travels down the cell chain.
  typedef struct packed {
    logic                     valid;
    logic signed [DIFF_W-1:0] diff;
    logic [SLOT_W-1:0]        age;
    logic [SLOT_W-1:0]        slot;
  } cand_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

  function automatic logic [SCORE_W-1:0] clamp_score(input logic signed [RAW_W-1:0] raw);
    logic [SCORE_W-1:0] res;
    if (raw < 0) res = '0;
    else if (raw > $signed({2'b00, ONE_Q15})) res = ONE_Q15;
    else res = raw[SCORE_W-1:0];
    return res;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // True when a ranks ahead of b: larger difference first, older first on ties.
  function automatic logic ranks_before(input cand_t a, input cand_t b);
    return (a.diff > b.diff) || ((a.diff == b.diff) && (a.age < b.age));
  endfunction

endpackage

// ===== sv/frts_in_if.sv =====
// Input channel of the selector: one append or select request per transaction.
interface frts_in_if import frts_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic signed [RAW_W-1:0] student_score;
  logic signed [RAW_W-1:0] teacher_score;
  logic [SEL_W-1:0]        select_count;
  logic signed [RAW_W-1:0] student_floor;

  modport source(output valid, opcode, student_score, teacher_score, select_count,
                 student_floor, input ready);
  modport sink(input valid, opcode, student_score, teacher_score, select_count,
               student_floor, output ready);
endinterface

// ===== sv/frts_out_if.sv =====
// Output channel of the selector: one result item per transaction.
interface frts_out_if import frts_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [SLOT_W-1:0]        slot_index;
  logic signed [DIFF_W-1:0] entry_value;
  logic                     item_valid;
  logic                     last;
  logic                     passed_filter;
  logic                     was_evicted;
  logic [CNT_W-1:0]         seen_total;
  logic [CNT_W-1:0]         filtered_total;
  logic [CNT_W-1:0]         evicted_total;
  logic signed [DIFF_W-1:0] mean_difference;
  logic [SCORE_W-1:0]       mean_student;
  logic [SCORE_W-1:0]       mean_teacher;

  modport source(output valid, slot_index, entry_value, item_valid, last, passed_filter,
                 was_evicted, seen_total, filtered_total, evicted_total, mean_difference,
                 mean_student, mean_teacher, input ready);
  modport sink(input valid, slot_index, entry_value, item_valid, last, passed_filter,
               was_evicted, seen_total, filtered_total, evicted_total, mean_difference,
               mean_student, mean_teacher, output ready);
endinterface

// ===== sv/frts_cell.sv =====
// One cell of the systolic top-k chain: keeps the better candidate, passes the other on.
module frts_cell import frts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  cand_t     cand_in,
  input  cand_t     neighbor,
  output cand_t     hold,
  output cand_t     pass
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      hold <= '0;
      pass <= '0;
    end else if (ctl.shift) begin
      hold <= neighbor;
      pass <= '0;
    end else if (cand_in.valid) begin
      if (!hold.valid) begin
        hold <= cand_in;
        pass <= '0;
      end else if (ranks_before(cand_in, hold)) begin
        hold <= cand_in;
        pass <= hold;
      end else begin
        pass <= cand_in;
      end
    end else begin
      pass.valid <= 1'b0;
    end
  end

endmodule

// ===== sv/frts_div.sv =====
// Restoring divider, one quotient bit per cycle, for the running-mean updates.
module frts_div import frts_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [QUO_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  logic             busy;
  logic [4:0]       cnt;
  logic [CNT_W-1:0] rem;
  logic [QUO_W-1:0] q;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   trial_sub;
  logic             fits;

  assign trial     = {rem, q[QUO_W-1]};
  assign trial_sub = trial - {1'b0, divisor};
  assign fits      = (trial >= {1'b0, divisor});
  assign quotient  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= 5'(QUO_W - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
    end else if (busy) begin
      q   <= {q[QUO_W-2:0], fits};
      rem <= fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

endmodule

// ===== sv/filtered_ring_topk_selector.sv =====
// Top level of the filtered ring top-k selector: ring memory, counters, means and ranking.
//
// The block handles one request at a time. An append writes the clamped scores into the
// ring and returns one result; when the teacher score passes the threshold, the three
// running means are first updated one after another on a shared one-bit-per-cycle
// divider. A select reads the ring one slot per cycle, lets the top-k cell chain settle,
// and then hands out one ranked result per cycle while the sink takes them, at most k of
// them, or a single result with item_valid low when nothing qualifies. Ties in the
// difference go to the older entry, whose age is derived from the write pointer. The
// threshold register sits at byte address 0; a write of zero restores the default 0.20
// and values above 1.0 are held at 1.0. Counters saturate at 2^32-1.
module filtered_ring_topk_selector import frts_pkg::*; #(
  parameter int RING_DEPTH = 64,
  parameter int MAX_SELECT = 64
) (
  input  logic        clk,
  input  logic        rst,
  frts_in_if.sink     in_ch,
  frts_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FW      = $clog2(RING_DEPTH + 1);
  localparam int DRAIN_W = $clog2(MAX_SELECT + 3);
  localparam int WORD_W  = 2 * SCORE_W + DIFF_W;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DIV_GO   = 3'd1;
  localparam logic [2:0] S_DIV_WAIT = 3'd2;
  localparam logic [2:0] S_APP_OUT  = 3'd3;
  localparam logic [2:0] S_SCAN     = 3'd4;
  localparam logic [2:0] S_DRAIN    = 3'd5;
  localparam logic [2:0] S_EMIT     = 3'd6;

  localparam logic [1:0] M_DIFF    = 2'd0;
  localparam logic [1:0] M_STUDENT = 2'd1;
  localparam logic [1:0] M_TEACHER = 2'd2;

  // Configuration register.
  logic [THRESH_W-1:0] thresh;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign prdata = {16'd0, thresh};
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_DEFAULT;
    end else if (cfg_wr) begin
      if (pwdata[15:0] == '0) thresh <= THRESH_DEFAULT;
      else if (pwdata[15:0] > ONE_Q15) thresh <= ONE_Q15;
      else thresh <= pwdata[15:0];
    end
  end

  // Control state.
  logic [2:0]         state;
  logic [AW-1:0]      wp;
  logic [FW-1:0]      fill;
  logic [CNT_W-1:0]   seen_cnt, filt_cnt, evict_cnt;
  logic signed [ACC_W-1:0] acc_diff, acc_stud, acc_teach;
  logic [1:0]         m_sel;
  logic               m_neg;

  // Latched request.
  logic [SCORE_W-1:0]       app_s, app_t;
  logic signed [DIFF_W-1:0] app_d;
  logic [AW-1:0]            app_slot;
  logic                     app_pass, app_evict;
  logic [SEL_W-1:0]         k_eff;
  logic [SCORE_W-1:0]       floor_q;

  logic in_acc;
  logic [SCORE_W-1:0]       in_s, in_t;
  logic signed [DIFF_W-1:0] in_d;

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_s        = clamp_score(in_ch.student_score);
  assign in_t        = clamp_score(in_ch.teacher_score);
  assign in_d        = $signed({1'b0, in_s}) - $signed({1'b0, in_t});

  // Ring memory: {student, teacher, difference} per slot.
  logic [WORD_W-1:0] ring [RING_DEPTH];
  logic [WORD_W-1:0] rd_word;
  logic [AW-1:0]     scan_addr;
  logic [AW-1:0]     rd_slot;
  logic              rd_v;

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.opcode == OP_APPEND) ring[wp] <= {in_s, in_t, in_d};
    rd_word <= ring[scan_addr];
  end

  // Divider for the mean updates.
  logic                    div_start, div_done;
  logic [QUO_W-1:0]        div_q, div_mag;
  logic signed [ACC_W-1:0] m_acc;
  logic signed [ACC_W:0]   m_x, m_delta;

  always_comb begin
    unique case (m_sel)
      M_DIFF:    begin m_acc = acc_diff;  m_x = (ACC_W+1)'(app_d) <<< 8; end
      M_STUDENT: begin m_acc = acc_stud;  m_x = $signed({2'b00, app_s, 8'd0}); end
      M_TEACHER: begin m_acc = acc_teach; m_x = $signed({2'b00, app_t, 8'd0}); end
      default:   begin m_acc = acc_diff;  m_x = '0; end
    endcase
    m_delta = m_x - (ACC_W+1)'(m_acc);
    div_mag = m_delta[ACC_W] ? QUO_W'(-m_delta) : QUO_W'(m_delta);
  end

  assign div_start = (state == S_DIV_GO);

  frts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_mag),
    .divisor  (filt_cnt),
    .done     (div_done),
    .quotient (div_q)
  );

  // Scan stage: filter the slot read last cycle and feed it into the cell chain.
  cand_t                    cand0;
  logic [SCORE_W-1:0]       rd_s, rd_t;
  logic signed [DIFF_W-1:0] rd_d;
  logic [SLOT_W:0]          age_wide;

  assign rd_s = rd_word[WORD_W-1 -: SCORE_W];
  assign rd_t = rd_word[DIFF_W +: SCORE_W];
  assign rd_d = rd_word[DIFF_W-1:0];

  always_comb begin
    if (rd_slot >= wp) age_wide = (SLOT_W+1)'(rd_slot) - (SLOT_W+1)'(wp);
    else age_wide = (SLOT_W+1)'(rd_slot) + (SLOT_W+1)'(RING_DEPTH) - (SLOT_W+1)'(wp);
    cand0.valid = rd_v && (FW'(rd_slot) < fill) && (rd_t <= thresh) && (rd_s >= floor_q);
    cand0.diff  = rd_d;
    cand0.age   = age_wide[SLOT_W-1:0];
    cand0.slot  = SLOT_W'(rd_slot);
  end

  // Cell chain.
  cand_t     hold [MAX_SELECT];
  cand_t     pass [MAX_SELECT];
  cell_ctl_t ctl;
  logic      out_free;
  logic      emit_go;
  logic [SEL_W-1:0]   ncand, emit_left;
  logic [DRAIN_W-1:0] drain_cnt;

  assign out_free  = !out_ch.valid || out_ch.ready;
  assign emit_go   = (state == S_EMIT) && out_free;
  assign ctl.clear = in_acc && (in_ch.opcode == OP_SELECT);
  assign ctl.shift = emit_go && (emit_left != '0);

  for (genvar i = 0; i < MAX_SELECT; i++) begin : g_cell
    cand_t c_in, c_nb;
    if (i == 0) begin : g_first
      assign c_in = cand0;
    end else begin : g_mid
      assign c_in = pass[i-1];
    end
    if (i == MAX_SELECT - 1) begin : g_tail
      assign c_nb = '0;
    end else begin : g_body
      assign c_nb = hold[i+1];
    end
    frts_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .cand_in  (c_in),
      .neighbor (c_nb),
      .hold     (hold[i]),
      .pass     (pass[i])
    );
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      fill      <= '0;
      seen_cnt  <= '0;
      filt_cnt  <= '0;
      evict_cnt <= '0;
      acc_diff  <= '0;
      acc_stud  <= '0;
      acc_teach <= '0;
      m_sel     <= M_DIFF;
      rd_v      <= 1'b0;
      scan_addr <= '0;
      ncand     <= '0;
      emit_left <= '0;
      drain_cnt <= '0;
    end else begin
      rd_v <= 1'b0;
      if (cand0.valid && ncand != SEL_W'(MAX_SELECT)) ncand <= ncand + 1'b1;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (in_ch.opcode == OP_APPEND) begin
              seen_cnt <= sat_inc(seen_cnt);
              if (fill == FW'(RING_DEPTH)) evict_cnt <= sat_inc(evict_cnt);
              else fill <= fill + 1'b1;
              wp <= (wp == AW'(RING_DEPTH - 1)) ? '0 : wp + 1'b1;
              m_sel <= M_DIFF;
              if (in_t <= thresh) begin
                filt_cnt <= sat_inc(filt_cnt);
                state    <= S_DIV_GO;
              end else begin
                state <= S_APP_OUT;
              end
            end else begin
              scan_addr <= '0;
              ncand     <= '0;
              state     <= S_SCAN;
            end
          end
        end
        S_DIV_GO: begin
          m_neg <= m_delta[ACC_W];
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            unique case (m_sel)
              M_DIFF:    acc_diff  <= m_neg ? acc_diff - ACC_W'(div_q)
                                            : acc_diff + ACC_W'(div_q);
              M_STUDENT: acc_stud  <= m_neg ? acc_stud - ACC_W'(div_q)
                                            : acc_stud + ACC_W'(div_q);
              default:   acc_teach <= m_neg ? acc_teach - ACC_W'(div_q)
                                            : acc_teach + ACC_W'(div_q);
            endcase
            if (m_sel == M_TEACHER) begin
              state <= S_APP_OUT;
            end else begin
              m_sel <= m_sel + 1'b1;
              state <= S_DIV_GO;
            end
          end
        end
        S_APP_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        S_SCAN: begin
          rd_v      <= 1'b1;
          rd_slot   <= scan_addr;
          scan_addr <= scan_addr + 1'b1;
          if (scan_addr == AW'(RING_DEPTH - 1)) begin
            drain_cnt <= '0;
            state     <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          drain_cnt <= drain_cnt + 1'b1;
          if (drain_cnt == DRAIN_W'(MAX_SELECT + 1)) begin
            emit_left <= (ncand < k_eff) ? ncand : k_eff;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (emit_left != '0) emit_left <= emit_left - 1'b1;
            if (emit_left == '0 || emit_left == SEL_W'(1)) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      app_s     <= in_s;
      app_t     <= in_t;
      app_d     <= in_d;
      app_slot  <= wp;
      app_pass  <= (in_t <= thresh);
      app_evict <= (fill == FW'(RING_DEPTH));
      k_eff     <= (in_ch.select_count > SEL_W'(MAX_SELECT)) ? SEL_W'(MAX_SELECT)
                                                           : in_ch.select_count;
      floor_q   <= clamp_score(in_ch.student_floor);
    end
  end

  // Output register: a result waits here until the sink takes the transaction.
  logic                    load_app;
  logic signed [ACC_W:0]   rnd_d, rnd_s, rnd_t;

  assign load_app = (state == S_APP_OUT) && out_free;
  assign rnd_d = (ACC_W+1)'(acc_diff) + (ACC_W+1)'(128);
  assign rnd_s = (ACC_W+1)'(acc_stud) + (ACC_W+1)'(128);
  assign rnd_t = (ACC_W+1)'(acc_teach) + (ACC_W+1)'(128);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (load_app || emit_go) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_app || emit_go) begin
      out_ch.seen_total      <= seen_cnt;
      out_ch.filtered_total  <= filt_cnt;
      out_ch.evicted_total   <= evict_cnt;
      out_ch.mean_difference <= rnd_d[8 +: DIFF_W];
      out_ch.mean_student    <= rnd_s[8 +: SCORE_W];
      out_ch.mean_teacher    <= rnd_t[8 +: SCORE_W];
      if (load_app) begin
        out_ch.slot_index    <= SLOT_W'(app_slot);
        out_ch.entry_value   <= app_d;
        out_ch.item_valid    <= 1'b1;
        out_ch.last          <= 1'b1;
        out_ch.passed_filter <= app_pass;
        out_ch.was_evicted   <= app_evict;
      end else begin
        out_ch.passed_filter <= 1'b0;
        out_ch.was_evicted   <= 1'b0;
        if (emit_left == '0) begin
          out_ch.slot_index  <= '0;
          out_ch.entry_value <= '0;
          out_ch.item_valid  <= 1'b0;
          out_ch.last        <= 1'b1;
        end else begin
          out_ch.slot_index  <= hold[0].slot;
          out_ch.entry_value <= hold[0].diff;
          out_ch.item_valid  <= 1'b1;
          out_ch.last        <= (emit_left == SEL_W'(1));
        end
      end
    end
  end

  // The ring never records more entries than it has slots.
  assert property (@(posedge clk) disable iff (rst) fill <= FW'(RING_DEPTH))
    else $error("ring fill count exceeds depth");

  // An empty select answer is always the final result of its request.
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.item_valid |-> out_ch.last)
    else $error("empty result without last");

  // The divider only reports completion while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst) div_done |-> state == S_DIV_WAIT)
    else $error("divider finished outside a mean update");

  // Every ranked result handed out comes from a filled cell.
  assert property (@(posedge clk) disable iff (rst)
    emit_go && emit_left != '0 |-> hold[0].valid)
    else $error("ranked result taken from an empty cell");

endmodule
